// ===== hdl/lsta_pkg.sv =====
// Shared types and constants for the listmode scatter TOF adder.
package lsta_pkg;

   // Default geometry of the scanner.
   localparam int TRANS_BLOCKS_DEF       = 24;
   localparam int AXIAL_BLOCKS_DEF       = 8;
   localparam int CRYSTALS_PER_BLOCK_DEF = 13;
   localparam int AXIAL_PITCH_DEF        = 14;
   localparam int TOF_BINS_DEF           = 11;
   localparam int BLOCK_PAIRS_DEF        = 156;

   // TOF offsets are clamped to plus or minus this many fine units.
   localparam int TOF_LIMIT = 21;
   // Width of a TOF bin number.
   localparam int BIN_W = 5;

   // Command codes of an input beat.
   typedef enum logic [1:0] {
      FUNC_MAP     = 2'd0,
      FUNC_SCATTER = 2'd1,
      FUNC_COUNT   = 2'd2,
      FUNC_EVENT   = 2'd3
   } func_type;

   // Event data that rides along with the divider.
   typedef struct packed {
      logic [31:0] prior;
      logic        unmapped;
      logic        zero;
   } tag_type;

endpackage

// ===== hdl/listmode_scatter_tof_add.sv =====
// Top level: pipelined scatter estimate adder for listmode coincidence events.
// Throughput: one beat per cycle while busy is low; the 49-stage restoring divider is fully pipelined.
// Load beats write their store at the same stage where events read it, so order is kept.
// After reset, busy is high while all TRANS_BLOCKS*TRANS_BLOCKS pair map entries are cleared.
// Results are strobed for one cycle; the receiver cannot stall them.
module listmode_scatter_tof_add #(
   parameter int TRANS_BLOCKS       = lsta_pkg::TRANS_BLOCKS_DEF,
   parameter int AXIAL_BLOCKS       = lsta_pkg::AXIAL_BLOCKS_DEF,
   parameter int CRYSTALS_PER_BLOCK = lsta_pkg::CRYSTALS_PER_BLOCK_DEF,
   parameter int AXIAL_PITCH        = lsta_pkg::AXIAL_PITCH_DEF,
   parameter int TOF_BINS           = lsta_pkg::TOF_BINS_DEF,
   parameter int BLOCK_PAIRS        = lsta_pkg::BLOCK_PAIRS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [8:0]  req_trans_crystal_a,
   input  logic [6:0]  req_axial_crystal_a,
   input  logic [8:0]  req_trans_crystal_b,
   input  logic [6:0]  req_axial_crystal_b,
   input  logic signed [15:0] req_tof_offset,
   input  logic signed [31:0] req_prior_value,
   input  logic [16:0] req_load_address,
   input  logic [31:0] req_load_data,
   input  logic [4:0]  req_pair_block_a,
   input  logic [4:0]  req_pair_block_b,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_corrected_value,
   output logic        rsp_pair_unmapped,
   output logic        rsp_saturated
);
   import lsta_pkg::*;

   localparam int MAP_DEPTH = TRANS_BLOCKS * TRANS_BLOCKS;
   localparam int CNT_DEPTH = AXIAL_BLOCKS * AXIAL_BLOCKS * BLOCK_PAIRS;
   localparam int SC_DEPTH  = CNT_DEPTH * TOF_BINS;
   localparam int TBW = $clog2(TRANS_BLOCKS);
   localparam int MAW = $clog2(MAP_DEPTH);
   localparam int APW = (AXIAL_BLOCKS > 1) ? $clog2(AXIAL_BLOCKS * AXIAL_BLOCKS) : 1;
   localparam int CAW = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
   localparam int SAW = (SC_DEPTH > 1) ? $clog2(SC_DEPTH) : 1;
   // Reciprocal constants for division of crystal numbers.
   localparam int ST = 9 + 6;
   localparam int SA = 7 + 6;
   localparam int MT = (1 << ST) / CRYSTALS_PER_BLOCK;
   localparam int MA = (1 << SA) / AXIAL_PITCH;
   localparam int PTW = 9 + ST + 1;
   localparam int PAW = 7 + SA + 1;
   // Divider widths: numerator (sum << 15) + count, divisor count << 1.
   localparam int XW = 49;
   localparam int YW = 33;

   // ---------------- Stage 1: input registers ----------------
   logic        v1_ff;
   func_type    func1_ff;
   logic [8:0]  cta1_ff, ctb1_ff;
   logic [6:0]  caa1_ff, cab1_ff;
   logic signed [15:0] tof1_ff;
   logic [31:0] prior1_ff, data1_ff;
   logic [16:0] addr1_ff;
   logic [4:0]  pa1_ff, pb1_ff;

   logic          clearing_ff;
   logic [MAW-1:0] clr_ff;

   assign busy = clearing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      func1_ff  <= func_type'(req_func);
      cta1_ff   <= req_trans_crystal_a;
      ctb1_ff   <= req_trans_crystal_b;
      caa1_ff   <= req_axial_crystal_a;
      cab1_ff   <= req_axial_crystal_b;
      tof1_ff   <= req_tof_offset;
      prior1_ff <= req_prior_value;
      addr1_ff  <= req_load_address;
      data1_ff  <= req_load_data;
      pa1_ff    <= req_pair_block_a;
      pb1_ff    <= req_pair_block_b;
   end

   // TOF clamp and bin selection.
   logic signed [6:0] tcl;
   logic [5:0] u_in;
   logic [BIN_W-1:0] bin1_in, bin2_in, raw1, raw2;

   always_comb begin
      if (tof1_ff < -16'(TOF_LIMIT)) begin
         tcl = -7'(TOF_LIMIT);
      end else if (tof1_ff > 16'(TOF_LIMIT)) begin
         tcl = 7'(TOF_LIMIT);
      end else begin
         tcl = 7'(tof1_ff);
      end
      u_in = 6'(tcl + 7'(TOF_LIMIT + 1));
      if (u_in[1:0] == 2'b00) begin
         raw1 = BIN_W'((u_in - 6'd2) >> 2);
         raw2 = raw1 + 1'b1;
      end else begin
         raw1 = BIN_W'(u_in >> 2);
         raw2 = raw1;
      end
      bin1_in = (raw1 > BIN_W'(TOF_BINS - 1)) ? BIN_W'(TOF_BINS - 1) : raw1;
      bin2_in = (raw2 > BIN_W'(TOF_BINS - 1)) ? BIN_W'(TOF_BINS - 1) : raw2;
   end

   // ---------------- Stage 2: reciprocal products ----------------
   logic        v2_ff;
   func_type    func2_ff;
   logic [8:0]  cta2_ff, ctb2_ff;
   logic [6:0]  caa2_ff, cab2_ff;
   logic [PTW-1:0] pta2_ff, ptb2_ff;
   logic [PAW-1:0] paa2_ff, pab2_ff;
   logic [BIN_W-1:0] b1_2_ff, b2_2_ff;
   logic [31:0] prior2_ff, data2_ff;
   logic [16:0] addr2_ff;
   logic [4:0]  pa2_ff, pb2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      func2_ff  <= func1_ff;
      cta2_ff   <= cta1_ff;
      ctb2_ff   <= ctb1_ff;
      caa2_ff   <= caa1_ff;
      cab2_ff   <= cab1_ff;
      pta2_ff   <= PTW'(cta1_ff) * PTW'(MT);
      ptb2_ff   <= PTW'(ctb1_ff) * PTW'(MT);
      paa2_ff   <= PAW'(caa1_ff) * PAW'(MA);
      pab2_ff   <= PAW'(cab1_ff) * PAW'(MA);
      b1_2_ff   <= bin1_in;
      b2_2_ff   <= bin2_in;
      prior2_ff <= prior1_ff;
      data2_ff  <= data1_ff;
      addr2_ff  <= addr1_ff;
      pa2_ff    <= pa1_ff;
      pb2_ff    <= pb1_ff;
   end

   // Quotient estimates are at most one low; correct them.
   logic [8:0] qta, qtb, ta_in, tb_in;
   logic [6:0] qaa, qab, aa_in, ab_in;

   always_comb begin
      qta = pta2_ff[ST+8:ST];
      qtb = ptb2_ff[ST+8:ST];
      qaa = paa2_ff[SA+6:SA];
      qab = pab2_ff[SA+6:SA];
      ta_in = (15'(cta2_ff) - 15'(qta) * 15'(CRYSTALS_PER_BLOCK) >= 15'(CRYSTALS_PER_BLOCK))
              ? qta + 1'b1 : qta;
      tb_in = (15'(ctb2_ff) - 15'(qtb) * 15'(CRYSTALS_PER_BLOCK) >= 15'(CRYSTALS_PER_BLOCK))
              ? qtb + 1'b1 : qtb;
      aa_in = (13'(caa2_ff) - 13'(qaa) * 13'(AXIAL_PITCH) >= 13'(AXIAL_PITCH))
              ? qaa + 1'b1 : qaa;
      ab_in = (13'(cab2_ff) - 13'(qab) * 13'(AXIAL_PITCH) >= 13'(AXIAL_PITCH))
              ? qab + 1'b1 : qab;
      // Map loads use the block numbers given directly.
      if (func2_ff == FUNC_MAP) begin
         ta_in = 9'(pa2_ff);
         tb_in = 9'(pb2_ff);
      end
   end

   // ---------------- Stage 3: blocks, pair map access ----------------
   logic        v3_ff;
   func_type    func3_ff;
   logic [8:0]  ta3_ff, tb3_ff;
   logic [6:0]  aa3_ff, ab3_ff;
   logic [BIN_W-1:0] b1_3_ff, b2_3_ff;
   logic [31:0] prior3_ff, data3_ff;
   logic [16:0] addr3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      func3_ff  <= func2_ff;
      ta3_ff    <= ta_in;
      tb3_ff    <= tb_in;
      aa3_ff    <= aa_in;
      ab3_ff    <= ab_in;
      b1_3_ff   <= b1_2_ff;
      b2_3_ff   <= b2_2_ff;
      prior3_ff <= prior2_ff;
      data3_ff  <= data2_ff;
      addr3_ff  <= addr2_ff;
   end

   // The map is symmetric, so it is kept once under the ordered pair.
   logic           inr_in;
   logic [TBW-1:0] lo, hi;
   logic [MAW-1:0] map_idx;
   logic [APW-1:0] ap_in;
   logic           map_we;
   logic [MAW-1:0] map_wa;
   logic [8:0]     map_wd;

   always_comb begin
      inr_in = (ta3_ff < 9'(TRANS_BLOCKS)) && (tb3_ff < 9'(TRANS_BLOCKS));
      if (func3_ff == FUNC_MAP) begin
         inr_in = inr_in && (addr3_ff < 17'(BLOCK_PAIRS));
      end else begin
         inr_in = inr_in && (aa3_ff < 7'(AXIAL_BLOCKS)) && (ab3_ff < 7'(AXIAL_BLOCKS));
      end
      if (ta3_ff < tb3_ff) begin
         lo = TBW'(ta3_ff);
         hi = TBW'(tb3_ff);
      end else begin
         lo = TBW'(tb3_ff);
         hi = TBW'(ta3_ff);
      end
      map_idx = MAW'(lo) * MAW'(TRANS_BLOCKS) + MAW'(hi);
      ap_in   = APW'(aa3_ff) * APW'(AXIAL_BLOCKS) + APW'(ab3_ff);
      map_we  = clearing_ff || (v3_ff && func3_ff == FUNC_MAP && inr_in);
      map_wa  = clearing_ff ? clr_ff : map_idx;
      map_wd  = clearing_ff ? 9'd0 : {1'b1, addr3_ff[7:0]};
   end

   // Clearing pass over the pair map after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == MAW'(MAP_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Pair map memory: valid bit and pair number.
   logic [8:0] map_mem [0:MAP_DEPTH-1];
   logic [8:0] map_rd_ff;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      map_rd_ff <= map_mem[map_idx];
   end

   // ---------------- Stage 4: pair lookup result ----------------
   logic        v4_ff, inr4_ff;
   func_type    func4_ff;
   logic [APW-1:0] ap4_ff;
   logic [BIN_W-1:0] b1_4_ff, b2_4_ff;
   logic [31:0] prior4_ff, data4_ff;
   logic [16:0] addr4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      inr4_ff   <= inr_in;
      func4_ff  <= func3_ff;
      ap4_ff    <= ap_in;
      b1_4_ff   <= b1_3_ff;
      b2_4_ff   <= b2_3_ff;
      prior4_ff <= prior3_ff;
      data4_ff  <= data3_ff;
      addr4_ff  <= addr3_ff;
   end

   logic           mapped_in;
   logic [CAW-1:0] cidx_in;

   always_comb begin
      mapped_in = inr4_ff && map_rd_ff[8] && (map_rd_ff[7:0] < 8'(BLOCK_PAIRS));
      cidx_in   = CAW'(ap4_ff) * CAW'(BLOCK_PAIRS) + CAW'(map_rd_ff[7:0]);
   end

   // ---------------- Stage 5: table addresses ----------------
   logic        v5_ff, mapped5_ff;
   func_type    func5_ff;
   logic [CAW-1:0] cidx5_ff;
   logic [BIN_W-1:0] b1_5_ff, b2_5_ff;
   logic [31:0] prior5_ff, data5_ff;
   logic [16:0] addr5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      mapped5_ff <= mapped_in;
      func5_ff   <= func4_ff;
      cidx5_ff   <= cidx_in;
      b1_5_ff    <= b1_4_ff;
      b2_5_ff    <= b2_4_ff;
      prior5_ff  <= prior4_ff;
      data5_ff   <= data4_ff;
      addr5_ff   <= addr4_ff;
   end

   logic [SAW-1:0] sa1_in, sa2_in, sbase;
   logic [CAW-1:0] ca_in;
   logic           wok_in;

   always_comb begin
      sbase = SAW'(cidx5_ff) * SAW'(TOF_BINS);
      if (func5_ff == FUNC_EVENT) begin
         sa1_in = sbase + SAW'(b1_5_ff);
         ca_in  = cidx5_ff;
      end else begin
         sa1_in = SAW'(addr5_ff);
         ca_in  = CAW'(addr5_ff);
      end
      sa2_in = sbase + SAW'(b2_5_ff);
      case (func5_ff)
         FUNC_SCATTER: wok_in = 32'(addr5_ff) < 32'(SC_DEPTH);
         FUNC_COUNT:   wok_in = 32'(addr5_ff) < 32'(CNT_DEPTH);
         default:      wok_in = 1'b0;
      endcase
   end

   // ---------------- Stage 6: table access ----------------
   logic        v6_ff, mapped6_ff, wok6_ff;
   func_type    func6_ff;
   logic [SAW-1:0] sa1_6_ff, sa2_6_ff;
   logic [CAW-1:0] ca6_ff;
   logic [31:0] prior6_ff, data6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      mapped6_ff <= mapped5_ff;
      wok6_ff    <= wok_in;
      func6_ff   <= func5_ff;
      sa1_6_ff   <= sa1_in;
      sa2_6_ff   <= sa2_in;
      ca6_ff     <= ca_in;
      prior6_ff  <= prior5_ff;
      data6_ff   <= data5_ff;
   end

   // Scatter table: one write port, two read ports.
   logic [31:0] sc_mem [0:SC_DEPTH-1];
   logic [31:0] sc1_ff, sc2_ff;

   always_ff @(posedge clock) begin
      if (v6_ff && func6_ff == FUNC_SCATTER && wok6_ff) begin
         sc_mem[sa1_6_ff] <= data6_ff;
      end
      sc1_ff <= sc_mem[sa1_6_ff];
      sc2_ff <= sc_mem[sa2_6_ff];
   end

   // Block count table.
   logic [31:0] cnt_mem [0:CNT_DEPTH-1];
   logic [31:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (v6_ff && func6_ff == FUNC_COUNT && wok6_ff) begin
         cnt_mem[ca6_ff] <= data6_ff;
      end
      cnt_ff <= cnt_mem[ca6_ff];
   end

   // ---------------- Stage 7: sum and divider operands ----------------
   logic        v7_ff, mapped7_ff;
   logic [31:0] prior7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff && func6_ff == FUNC_EVENT;
      end
      mapped7_ff <= mapped6_ff;
      prior7_ff  <= prior6_ff;
   end

   logic [32:0]   sum_in;
   logic [XW-1:0] x_in;
   logic [YW-1:0] y_in;
   tag_type       tag_in;

   always_comb begin
      sum_in          = {1'b0, sc1_ff} + {1'b0, sc2_ff};
      x_in            = {1'b0, sum_in, 15'd0} + XW'(cnt_ff);
      y_in            = {cnt_ff, 1'b0};
      tag_in.prior    = prior7_ff;
      tag_in.unmapped = !mapped7_ff;
      tag_in.zero     = (cnt_ff == 32'd0);
   end

   // ---------------- Divider: one quotient bit per stage ----------------
   logic          dv_ff [0:XW];
   logic [XW-1:0] dx_ff [0:XW];
   logic [YW-1:0] dy_ff [0:XW];
   logic [YW-1:0] dr_ff [0:XW];
   logic [XW-1:0] dq_ff [0:XW];
   tag_type       dt_ff [0:XW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v7_ff;
      end
      dx_ff[0] <= x_in;
      dy_ff[0] <= y_in;
      dr_ff[0] <= '0;
      dq_ff[0] <= '0;
      dt_ff[0] <= tag_in;
   end

   for (genvar i = 0; i < XW; i++) begin : g_div
      logic [YW:0]   trial;
      logic          take;
      logic [YW-1:0] r_in;
      logic [XW-1:0] q_in;

      // Shift in the next numerator bit, subtract when the divisor fits.
      always_comb begin
         trial = {dr_ff[i], dx_ff[i][XW-1-i]};
         take  = trial >= {1'b0, dy_ff[i]};
         r_in  = take ? YW'(trial - {1'b0, dy_ff[i]}) : YW'(trial);
         q_in  = dq_ff[i];
         q_in[XW-1-i] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1] <= 1'b0;
         end else begin
            dv_ff[i+1] <= dv_ff[i];
         end
         dx_ff[i+1] <= dx_ff[i];
         dy_ff[i+1] <= dy_ff[i];
         dr_ff[i+1] <= r_in;
         dq_ff[i+1] <= q_in;
         dt_ff[i+1] <= dt_ff[i];
      end
   end

   // ---------------- Output stage: add, saturate, flag ----------------
   tag_type        ft;
   logic [XW-1:0]  fq;
   logic           big, over;
   logic [33:0]    total;
   logic [31:0]    val_in;
   logic           unm_in, sat_in;

   always_comb begin
      ft    = dt_ff[XW];
      fq    = dq_ff[XW];
      big   = |fq[XW-1:32];
      total = {{2{ft.prior[31]}}, ft.prior} + {2'b00, fq[31:0]};
      over  = big || ($signed(total) > $signed(34'h07FFFFFFF));
      if (ft.unmapped) begin
         val_in = ft.prior;
         unm_in = 1'b1;
         sat_in = 1'b0;
      end else if (ft.zero || over) begin
         val_in = 32'h7FFFFFFF;
         unm_in = 1'b0;
         sat_in = 1'b1;
      end else begin
         val_in = total[31:0];
         unm_in = 1'b0;
         sat_in = 1'b0;
      end
   end

   logic        rsp_valid_ff, rsp_unm_ff, rsp_sat_ff;
   logic [31:0] rsp_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_ff[XW];
      end
      rsp_val_ff <= val_in;
      rsp_unm_ff <= unm_in;
      rsp_sat_ff <= sat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_value = rsp_val_ff;
   assign rsp_pair_unmapped   = rsp_unm_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule
